>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_ON_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_THRU_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> design/ttwc_pkg.sv
// types and constants of the track time window clipper
package ttwc_pkg;

   // width of the interpolation datapath words
   localparam int CALC_BITS = 64;
   // coordinate bits plus fraction bits of the interpolation product
   localparam int FIX_BITS = 62;

   localparam int AXIS_COUNT = 3;
   localparam int AXIS_BITS = 2;

   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 4;
   localparam int REG_SEL_BIT = 3;

   typedef enum logic {
      REG_WINDOW_START,
      REG_WINDOW_END
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIV,
      ST_MAG,
      ST_MUL,
      ST_ADD,
      ST_EMIT
   } state_type;

endpackage

>>> design/ttwc_req_if.sv
// track point channel into the clipper
interface ttwc_req_if #(
   parameter int COORD_BITS = 32,
   parameter int TIME_BITS = 48
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] pos_z;
   logic signed [TIME_BITS-2:0]  point_time;
   logic signed [TIME_BITS-2:0]  track_offset;
   logic                         first_point;
   logic                         last_point;

   modport source (
      output valid, pos_x, pos_y, pos_z, point_time, track_offset, first_point, last_point,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, pos_z, point_time, track_offset, first_point, last_point,
      output ready
   );
endinterface

>>> design/ttwc_rsp_if.sv
// clipped point channel out of the clipper
interface ttwc_rsp_if #(
   parameter int COORD_BITS = 32
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] out_x;
   logic signed [COORD_BITS-1:0] out_y;
   logic signed [COORD_BITS-1:0] out_z;
   logic                         starts_line;
   logic                         ends_line;

   modport source (
      output valid, out_x, out_y, out_z, starts_line, ends_line,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_z, starts_line, ends_line,
      output ready
   );
endinterface

>>> design/track_time_window_clipper.sv
// Clips each track's polyline to the time window (window_start, window_end) written over the
// csr port (start at byte 0, end at byte 8); if the end is below the start, every point passes.
// One point is taken at a time. A point that is dropped or only stored goes from the decide
// state back to idle, a point that passes through also goes through the emit state, which
// loads the output register. A boundary point, where the track enters or leaves the window,
// is interpolated: a restoring divider shares one 64-bit subtractor to form the fraction, then
// one multiplier is reused for the three axes, each in a magnitude, multiply and add step. The
// output register lets the next point be taken while a result waits.
module track_time_window_clipper
   import ttwc_pkg::*;
#(
   parameter int COORD_BITS = 32,
   parameter int TIME_BITS = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   ttwc_req_if.sink                 req_ch,
   ttwc_rsp_if.source               rsp_ch,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int FRAC_BITS = FIX_BITS - COORD_BITS;
   localparam int PROD_BITS = COORD_BITS + FRAC_BITS;
   localparam int CNT_BITS = $clog2(FRAC_BITS);
   localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (FRAC_BITS - 1);

   // configuration
   logic signed [TIME_BITS-1:0] win_start_ff;
   logic signed [TIME_BITS-1:0] win_end_ff;
   logic                        csr_write;
   reg_index_type               csr_reg;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_reg = reg_index_type'(csr_paddr[REG_SEL_BIT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= '0;
         win_end_ff <= {1'b0, {(TIME_BITS-1){1'b1}}};
      end else if (csr_write) begin
         unique case (csr_reg)
            REG_WINDOW_START: win_start_ff <= csr_pwdata[TIME_BITS-1:0];
            REG_WINDOW_END:   win_end_ff <= csr_pwdata[TIME_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_WINDOW_START: csr_prdata = CSR_DATA_BITS'(win_start_ff);
         REG_WINDOW_END:   csr_prdata = CSR_DATA_BITS'(win_end_ff);
      endcase
   end

   // sequencer and datapath registers
   state_type                   state_ff, state_in;
   logic signed [COORD_BITS-1:0] cur_ff [AXIS_COUNT];
   logic signed [COORD_BITS-1:0] cur_in [AXIS_COUNT];
   logic signed [TIME_BITS-1:0] cur_t_ff, cur_t_in;
   logic                        first_ff, first_in;
   logic                        last_ff, last_in;
   logic signed [COORD_BITS-1:0] prev_ff [AXIS_COUNT];
   logic signed [COORD_BITS-1:0] prev_in [AXIS_COUNT];
   logic signed [TIME_BITS-1:0] prev_time_ff, prev_time_in;
   logic                        have_prev_ff, have_prev_in;
   logic                        line_started_ff, line_started_in;
   logic                        track_finished_ff, track_finished_in;
   logic [CALC_BITS-1:0]        div_rem_ff, div_rem_in;
   logic [CALC_BITS-1:0]        div_den_ff, div_den_in;
   logic [FRAC_BITS-1:0]        quot_ff, quot_in;
   logic [CNT_BITS-1:0]         count_ff, count_in;
   logic [AXIS_BITS-1:0]        axis_ff, axis_in;
   logic                        neg_ff, neg_in;
   logic [COORD_BITS-1:0]       mag_ff, mag_in;
   logic [PROD_BITS-1:0]        prod_ff, prod_in;
   logic                        keep_ff, keep_in;
   logic signed [COORD_BITS-1:0] res_ff [AXIS_COUNT];
   logic signed [COORD_BITS-1:0] res_in [AXIS_COUNT];
   logic                        res_start_ff, res_start_in;
   logic                        res_end_ff, res_end_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] out_x_ff, out_x_in;
   logic signed [COORD_BITS-1:0] out_y_ff, out_y_in;
   logic signed [COORD_BITS-1:0] out_z_ff, out_z_in;
   logic                        out_start_ff, out_start_in;
   logic                        out_end_ff, out_end_in;
   logic                        req_ready;

   // decision terms
   logic                        have_eff, started_eff, finished_eff;
   logic                        inverted, t_lt_ws, ws_lt_t, t_lt_we, we_lt_t;
   logic signed [TIME_BITS-1:0] win_sel;

   // shared units
   logic [CALC_BITS-1:0]        div_shift;
   logic [CALC_BITS:0]          div_diff;
   logic                        div_take;
   logic signed [COORD_BITS:0]  axis_diff;
   logic [COORD_BITS-1:0]       axis_off;

   assign have_eff = have_prev_ff & ~first_ff;
   assign started_eff = line_started_ff & ~first_ff;
   assign finished_eff = track_finished_ff & ~first_ff;
   assign inverted = win_end_ff < win_start_ff;
   assign t_lt_ws = cur_t_ff < win_start_ff;
   assign ws_lt_t = win_start_ff < cur_t_ff;
   assign t_lt_we = cur_t_ff < win_end_ff;
   assign we_lt_t = win_end_ff < cur_t_ff;
   assign win_sel = we_lt_t ? win_end_ff : win_start_ff;

   // one restoring step: remainder top bit out forces a subtract
   assign div_shift = {div_rem_ff[CALC_BITS-2:0], 1'b0};
   assign div_diff = {1'b0, div_shift} - {1'b0, div_den_ff};
   assign div_take = div_rem_ff[CALC_BITS-1] | ~div_diff[CALC_BITS];

   assign axis_diff = (COORD_BITS+1)'(cur_ff[axis_ff]) - (COORD_BITS+1)'(prev_ff[axis_ff]);
   assign axis_off = prod_ff[PROD_BITS-1 -: COORD_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         have_prev_ff <= 1'b0;
         line_started_ff <= 1'b0;
         track_finished_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         have_prev_ff <= have_prev_in;
         line_started_ff <= line_started_in;
         track_finished_ff <= track_finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      cur_t_ff <= cur_t_in;
      first_ff <= first_in;
      last_ff <= last_in;
      prev_ff <= prev_in;
      prev_time_ff <= prev_time_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      quot_ff <= quot_in;
      count_ff <= count_in;
      axis_ff <= axis_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      prod_ff <= prod_in;
      keep_ff <= keep_in;
      res_ff <= res_in;
      res_start_ff <= res_start_in;
      res_end_ff <= res_end_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_z_ff <= out_z_in;
      out_start_ff <= out_start_in;
      out_end_ff <= out_end_in;
   end

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      cur_t_in = cur_t_ff;
      first_in = first_ff;
      last_in = last_ff;
      prev_in = prev_ff;
      prev_time_in = prev_time_ff;
      have_prev_in = have_prev_ff;
      line_started_in = line_started_ff;
      track_finished_in = track_finished_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      quot_in = quot_ff;
      count_in = count_ff;
      axis_in = axis_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      prod_in = prod_ff;
      keep_in = keep_ff;
      res_in = res_ff;
      res_start_in = res_start_ff;
      res_end_in = res_end_ff;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      out_z_in = out_z_ff;
      out_start_in = out_start_ff;
      out_end_in = out_end_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               cur_in[0] = req_ch.pos_x;
               cur_in[1] = req_ch.pos_y;
               cur_in[2] = req_ch.pos_z;
               cur_t_in = TIME_BITS'(req_ch.point_time) + TIME_BITS'(req_ch.track_offset);
               first_in = req_ch.first_point;
               last_in = req_ch.last_point;
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            have_prev_in = have_eff;
            line_started_in = started_eff;
            track_finished_in = finished_eff;
            res_in = cur_ff;
            res_start_in = ~started_eff;
            res_end_in = 1'b0;
            keep_in = 1'b0;
            div_rem_in = CALC_BITS'(win_sel) - CALC_BITS'(prev_time_ff);
            div_den_in = CALC_BITS'(cur_t_ff) - CALC_BITS'(prev_time_ff);
            quot_in = '0;
            count_in = CNT_BITS'(FRAC_BITS - 1);
            state_in = ST_IDLE;
            priority if (inverted) begin
               line_started_in = 1'b1;
               state_in = ST_EMIT;
            end else if (finished_eff) begin
               state_in = ST_IDLE;
            end else if (first_ff && (last_ff || we_lt_t)) begin
               track_finished_in = 1'b1;
            end else if (t_lt_ws) begin
               prev_in = cur_ff;
               prev_time_in = cur_t_ff;
               have_prev_in = 1'b1;
            end else if (ws_lt_t && t_lt_we) begin
               line_started_in = 1'b1;
               if (!started_eff && have_eff) begin
                  // entering: anchor is replaced only after the interpolation
                  keep_in = 1'b1;
                  state_in = ST_DIV;
               end else begin
                  prev_in = cur_ff;
                  prev_time_in = cur_t_ff;
                  have_prev_in = 1'b1;
                  state_in = ST_EMIT;
               end
            end else if (we_lt_t) begin
               track_finished_in = 1'b1;
               if (have_eff) begin
                  line_started_in = 1'b1;
                  res_end_in = 1'b1;
                  state_in = ST_DIV;
               end
            end
            if (last_ff) begin
               track_finished_in = 1'b1;
            end
         end

         ST_DIV: begin
            div_rem_in = div_take ? div_diff[CALC_BITS-1:0] : div_shift;
            quot_in = {quot_ff[FRAC_BITS-2:0], div_take};
            if (count_ff == '0) begin
               axis_in = '0;
               state_in = ST_MAG;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end

         ST_MAG: begin
            neg_in = axis_diff[COORD_BITS];
            mag_in = axis_diff[COORD_BITS] ? COORD_BITS'(-axis_diff) : COORD_BITS'(axis_diff);
            state_in = ST_MUL;
         end

         ST_MUL: begin
            prod_in = PROD_BITS'(mag_ff) * PROD_BITS'(quot_ff) + ROUND_HALF;
            state_in = ST_ADD;
         end

         ST_ADD: begin
            res_in[axis_ff] = neg_ff ? prev_ff[axis_ff] - axis_off
                                     : prev_ff[axis_ff] + axis_off;
            if (axis_ff == AXIS_BITS'(AXIS_COUNT - 1)) begin
               if (keep_ff) begin
                  prev_in = cur_ff;
                  prev_time_in = cur_t_ff;
                  have_prev_in = 1'b1;
               end
               state_in = ST_EMIT;
            end else begin
               axis_in = axis_ff + 1'b1;
               state_in = ST_MAG;
            end
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_x_in = res_ff[0];
               out_y_in = res_ff[1];
               out_z_in = res_ff[2];
               out_start_in = res_start_ff;
               out_end_in = res_end_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.out_x = out_x_ff;
   assign rsp_ch.out_y = out_y_ff;
   assign rsp_ch.out_z = out_z_ff;
   assign rsp_ch.starts_line = out_start_ff;
   assign rsp_ch.ends_line = out_end_ff;

endmodule

>>> design/ttwc_checker.sv
// port-level checks of the track time window clipper, bound to the top level
`include "assert_macros.svh"

module ttwc_checker #(
   parameter int COORD_BITS = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COORD_BITS-1:0] out_x,
   input logic [COORD_BITS-1:0] out_y,
   input logic [COORD_BITS-1:0] out_z,
   input logic                  starts_line,
   input logic                  ends_line
);

   logic                      rsp_stall;
   logic [3*COORD_BITS+1:0]   rsp_beat;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_beat = {out_x, out_y, out_z, starts_line, ends_line};

   // output register comes out of reset empty
   `ASSERT_THRU_RST(a_rsp_empty_after_reset, reset |=> !rsp_valid, "result valid after reset")

   // one point in flight: a taken beat closes the input side
   `ASSERT_ON_CLK(a_one_point, req_valid && req_ready |=> !req_ready, "ready right after a beat")

   // a result is only produced while a point is being worked on
   `ASSERT_ON_CLK(a_rsp_from_work, $rose(rsp_valid) |-> !$past(req_ready), "result while idle")

   `ASSERT_ON_CLK(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_beat), "stalled beat changed")

endmodule

bind track_time_window_clipper ttwc_checker #(
   .COORD_BITS(COORD_BITS)
) u_ttwc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .out_x      (rsp_ch.out_x),
   .out_y      (rsp_ch.out_y),
   .out_z      (rsp_ch.out_z),
   .starts_line(rsp_ch.starts_line),
   .ends_line  (rsp_ch.ends_line)
);
